/* rtl/ffbpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffbpa_pkg;

  localparam int POOL_BYTES = 4096;
  localparam int MAX_BLOCKS = 32;

  localparam int OFS_W  = $clog2(POOL_BYTES);
  localparam int SIZE_W = OFS_W + 1;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;

  localparam logic [OFS_W-1:0] OFS_MAX   = OFS_W'(POOL_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_BLOCKS);

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_QUERY   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ZERO      = 3'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFS_W-1:0]  target_offset;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFS_W-1:0] granted_offset;
    logic             is_present;
  } out_t;

  typedef struct packed {
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] end_ofs;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan_go;
    logic       scan_on;
    logic       up_go;
    logic       dn_go;
    logic       mv_on;
    logic       ins;
    logic       del;
    logic       fin;
    logic [2:0] fin_st;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             is_alloc;
    logic             is_rel;
    logic             is_qry;
    logic             zero;
    logic             full;
    logic             empty;
    logic             fits_empty;
    logic             scan_hit;
    logic             scan_miss;
    logic             mv_done;
    logic [CNT_W-1:0] count;
  } st_t;

endpackage
`default_nettype wire

/* rtl/ffbpa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffbpa_datapath
  import ffbpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_item,
  input  wire cmd_t cmd,
  output st_t       st,
  output logic      out_valid,
  output out_t      out_item
);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_r;

  in_t              req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_ptr_r;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_at_r;
  logic [OFS_W-1:0] prev_end_r;
  logic [OFS_W-1:0] new_start_r;
  logic [OFS_W-1:0] new_end_r;
  logic [CNT_W-1:0] pos_r;
  logic             dir_up_r;
  logic [CNT_W-1:0] mv_ptr_r;
  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_addr_r;
  logic             out_valid_r;
  out_t             out_r;

  logic                    is_alloc, is_rel, is_qry;
  logic                    scan_issue, mv_issue, rd_en;
  logic [IDX_W-1:0]        raddr, mv_raddr, mv_waddr;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  entry_t                  wdata;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    chk, last;
  logic signed [SIZE_W:0]  gap;
  logic                    gap_ok, tail_ok, match, hit;
  logic [SIZE_W-1:0]       gap_end, tail_end;

  assign is_alloc = (req_r.func == FUNC_ALLOC);
  assign is_rel   = (req_r.func == FUNC_RELEASE);
  assign is_qry   = (req_r.func == FUNC_QUERY);
  assign cnt_m1   = count_r - CNT_W'(1);

  // scan: one entry read per cycle, checked when its data returns
  assign scan_issue = cmd.scan_on && (rd_ptr_r < count_r);
  assign chk        = cmd.scan_on && chk_vld_r;
  assign last       = ({1'b0, chk_at_r} == cnt_m1);

  assign gap      = $signed({2'b00, rdata_r.start_ofs} - {2'b00, prev_end_r}
                            - {{(SIZE_W){1'b0}}, 1'b1});
  assign gap_ok   = (chk_at_r != '0) && (gap >= $signed({1'b0, req_r.size_bytes}));
  assign tail_ok  = last && ({1'b0, OFS_MAX - rdata_r.end_ofs} > req_r.size_bytes);
  assign gap_end  = {1'b0, prev_end_r} + req_r.size_bytes;
  assign tail_end = {1'b0, rdata_r.end_ofs} + req_r.size_bytes;
  assign match    = (rdata_r.start_ofs == req_r.target_offset);
  assign hit      = chk && (is_alloc ? (gap_ok || tail_ok) : match);

  // move: copy one entry up (insert) or down (remove) per cycle
  always_comb begin
    if (dir_up_r) begin
      mv_issue = (mv_ptr_r > pos_r);
      mv_raddr = IDX_W'(mv_ptr_r - CNT_W'(1));
      mv_waddr = mv_ptr_r[IDX_W-1:0];
    end else begin
      mv_issue = (mv_ptr_r < count_r);
      mv_raddr = mv_ptr_r[IDX_W-1:0];
      mv_waddr = IDX_W'(mv_ptr_r - CNT_W'(1));
    end
  end

  assign rd_en = scan_issue || (cmd.mv_on && mv_issue);
  assign raddr = cmd.scan_on ? rd_ptr_r[IDX_W-1:0] : mv_raddr;
  assign we    = (cmd.mv_on && pend_vld_r) || cmd.ins;
  assign waddr = cmd.ins ? pos_r[IDX_W-1:0] : pend_addr_r;
  assign wdata = cmd.ins ? entry_t'{start_ofs: new_start_r, end_ofs: new_end_r} : rdata_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.fin;
      if (cmd.scan_go) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_on) begin
        chk_vld_r <= scan_issue;
      end
      if (cmd.up_go || cmd.dn_go) begin
        pend_vld_r <= 1'b0;
      end else if (cmd.mv_on) begin
        pend_vld_r <= mv_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= in_item;
      new_start_r <= '0;
      new_end_r   <= OFS_W'(in_item.size_bytes - SIZE_W'(1));
      pos_r       <= '0;
    end
    if (cmd.scan_go) begin
      rd_ptr_r <= '0;
    end else if (scan_issue) begin
      rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      chk_at_r <= rd_ptr_r[IDX_W-1:0];
    end
    if (chk) begin
      prev_end_r <= rdata_r.end_ofs;
    end
    if (hit) begin
      // tail placement goes after the last entry
      pos_r <= (is_alloc && !gap_ok) ? count_r : {1'b0, chk_at_r};
      if (is_alloc) begin
        if (gap_ok) begin
          new_start_r <= prev_end_r + OFS_W'(1);
          new_end_r   <= gap_end[OFS_W-1:0];
        end else begin
          new_start_r <= rdata_r.end_ofs + OFS_W'(1);
          new_end_r   <= tail_end[OFS_W-1:0];
        end
      end
    end
    if (cmd.up_go) begin
      dir_up_r <= 1'b1;
      mv_ptr_r <= count_r;
    end else if (cmd.dn_go) begin
      dir_up_r <= 1'b0;
      mv_ptr_r <= {1'b0, chk_at_r} + CNT_W'(1);
    end else if (cmd.mv_on && mv_issue) begin
      mv_ptr_r    <= dir_up_r ? (mv_ptr_r - CNT_W'(1)) : (mv_ptr_r + CNT_W'(1));
      pend_addr_r <= mv_waddr;
    end
    if (cmd.fin) begin
      out_r.status         <= cmd.fin_st;
      out_r.granted_offset <= (is_alloc && (cmd.fin_st == ST_OK)) ? new_start_r : '0;
      out_r.is_present     <= is_qry && hit;
    end
  end

  always_comb begin
    st.is_alloc   = is_alloc;
    st.is_rel     = is_rel;
    st.is_qry     = is_qry;
    st.zero       = (req_r.size_bytes == '0);
    st.full       = (count_r == CNT_FULL);
    st.empty      = (count_r == '0);
    st.fits_empty = (req_r.size_bytes < SIZE_W'(POOL_BYTES));
    st.scan_hit   = hit;
    st.scan_miss  = chk && last && !hit;
    st.mv_done    = cmd.mv_on && !mv_issue && !pend_vld_r;
    st.count      = count_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

/* rtl/ffbpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffbpa_ctrl
  import ffbpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire st_t  st,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_UP     = 6'b001000,
    S_INS    = 6'b010000,
    S_DN     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (st.is_alloc && st.zero) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = ST_ZERO;
          state_nxt  = S_IDLE;
        end else if (st.is_alloc && st.full) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = ST_FULL;
          state_nxt  = S_IDLE;
        end else if (st.is_alloc && st.empty) begin
          if (st.fits_empty) begin
            state_nxt = S_INS;
          end else begin
            cmd.fin    = 1'b1;
            cmd.fin_st = ST_NO_SPACE;
            state_nxt  = S_IDLE;
          end
        end else if (st.is_rel && st.empty) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else if (st.is_alloc || ((st.is_rel || st.is_qry) && !st.empty)) begin
          cmd.scan_go = 1'b1;
          state_nxt   = S_SCAN;
        end else begin
          // empty query or unused code
          cmd.fin    = 1'b1;
          cmd.fin_st = ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_on = 1'b1;
        if (st.scan_hit) begin
          priority if (st.is_alloc) begin
            cmd.up_go = 1'b1;
            state_nxt = S_UP;
          end else if (st.is_rel) begin
            cmd.dn_go = 1'b1;
            state_nxt = S_DN;
          end else begin
            cmd.fin    = 1'b1;
            cmd.fin_st = ST_OK;
            state_nxt  = S_IDLE;
          end
        end else if (st.scan_miss) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = st.is_alloc ? ST_NO_SPACE : (st.is_rel ? ST_NOT_FOUND : ST_OK);
          state_nxt  = S_IDLE;
        end
      end
      S_UP: begin
        cmd.mv_on = 1'b1;
        if (st.mv_done) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins    = 1'b1;
        cmd.fin    = 1'b1;
        cmd.fin_st = ST_OK;
        state_nxt  = S_IDLE;
      end
      S_DN: begin
        cmd.mv_on = 1'b1;
        if (st.mv_done) begin
          cmd.del    = 1'b1;
          cmd.fin    = 1'b1;
          cmd.fin_st = ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* rtl/first_fit_byte_pool_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// first-fit allocator over a byte pool, table of up to MAX_BLOCKS sorted blocks
// input: a beat is taken at a clock edge with start high and busy low;
//   in_item carries func, size_bytes and target_offset
// output: out_valid is high for exactly one cycle with out_item (status,
//   granted_offset, is_present); one result beat per input beat, in order
// trivial cases (zero size, full table, empty table, unused code) are settled
//   in the decide state; the first block into an empty table goes on to insert
// a scan reads one table entry per cycle from a single-port-read memory; an
//   allocate then moves the entries above the new one up, a release moves
//   them down, one per cycle through the same read port; scan and move
//   together cover the table once; the worst case is an allocate into the
//   lowest gap of a table one short of full
// busy drops in the cycle the result shows, so the next beat can be taken at
//   the edge ending it; no new beat is taken while one is in progress
// reset empties the table (count to zero); entry storage is not cleared
// the receiver cannot stall: each result is offered once
module first_fit_byte_pool_allocator
  import ffbpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  cmd_t cmd;
  st_t  st;

  ffbpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffbpa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a pending request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    st.count <= CNT_FULL)
    else $error("block count out of range");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> (st.count < CNT_FULL))
    else $error("insert into full table");

endmodule
`default_nettype wire

/* bench/tb_first_fit_byte_pool_allocator.sv */
`timescale 1ns / 1ps
module tb_first_fit_byte_pool_allocator;
  import ffbpa_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES = 19;
  localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 16;
  localparam int EXP_DEPTH = 16;

  typedef enum int {PH_CHURN, PH_FILL, PH_DRAIN, PH_BIG} phase_e;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } step_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  // shadow of the block table
  logic [OFS_W-1:0] pool_start [MAX_BLOCKS];
  logic [OFS_W-1:0] pool_end   [MAX_BLOCKS];
  logic [CNT_W-1:0] pool_count;

  // expected results in order of acceptance
  out_t exp_ring [EXP_DEPTH];
  int   exp_wr = 0;
  int   exp_rd = 0;
  out_t want;
  int   err_count;

  first_fit_byte_pool_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(string what, int got, int want_v);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want_v, $time);
    err_count++;
  endtask

  function automatic int find_block(logic [OFS_W-1:0] ofs);
    int i;
    for (i = 0; i < pool_count; i++)
      if (pool_start[i] == ofs) return i;
    return int'(pool_count);
  endfunction

  function automatic void place_block(int s, int e);
    int pos;
    int k;
    pos = 0;
    while (pos < pool_count && int'(pool_start[pos]) <= s) pos++;
    for (k = int'(pool_count); k > pos; k--) begin
      pool_start[k] = pool_start[k-1];
      pool_end[k]   = pool_end[k-1];
    end
    pool_start[pos] = OFS_W'(s);
    pool_end[pos]   = OFS_W'(e);
    pool_count++;
  endfunction

  // first fit between neighbors, then the tail; the space below the first block is skipped
  function automatic out_t apply_request(in_t req);
    out_t res;
    int   sz;
    int   slot;
    int   room;
    int   i;
    int   k;
    res  = '0;
    slot = -1;
    sz   = int'(req.size_bytes);
    case (req.func)
      FUNC_ALLOC: begin
        if (sz == 0) begin
          res.status = ST_ZERO;
        end else if (pool_count >= CNT_FULL) begin
          res.status = ST_FULL;
        end else if (pool_count == 0) begin
          if (POOL_BYTES > sz) slot = 0;
        end else begin
          for (i = 1; i < pool_count; i++) begin
            room = int'(pool_start[i]) - int'(pool_end[i-1]) - 1;
            if (slot < 0 && room > 0 && room >= sz) slot = int'(pool_end[i-1]) + 1;
          end
          room = POOL_BYTES - int'(pool_end[pool_count-1]) - 1;
          if (slot < 0 && room > sz) slot = int'(pool_end[pool_count-1]) + 1;
        end
        if (sz != 0 && pool_count < CNT_FULL) begin
          if (slot >= 0) begin
            place_block(slot, slot + sz - 1);
            res.granted_offset = OFS_W'(slot);
          end else begin
            res.status = ST_NO_SPACE;
          end
        end
      end
      FUNC_RELEASE: begin
        i = find_block(req.target_offset);
        if (i < pool_count) begin
          for (k = i; k + 1 < pool_count; k++) begin
            pool_start[k] = pool_start[k+1];
            pool_end[k]   = pool_end[k+1];
          end
          pool_count--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      FUNC_QUERY: res.is_present = (find_block(req.target_offset) < pool_count);
      default: ;
    endcase
    return res;
  endfunction

  function automatic step_t row(logic [1:0] f, int sz, int ofs, bit typed,
                                logic [2:0] st, int granted, bit present);
    step_t s;
    s.req.func            = f;
    s.req.size_bytes      = SIZE_W'(sz);
    s.req.target_offset   = OFS_W'(ofs);
    s.typed               = typed;
    s.want.status         = st;
    s.want.granted_offset = OFS_W'(granted);
    s.want.is_present     = present;
    return s;
  endfunction

  // sizes cluster around the current gaps and the tail room to hit the fit edges
  function automatic int pick_size(int small_max);
    int r;
    int room;
    int i;
    r    = $urandom_range(0, 19);
    room = -1;
    if (pool_count != 0 && (r == 2 || r == 3))
      room = POOL_BYTES - int'(pool_end[pool_count-1]) - 1;
    if (pool_count > 1 && (r == 4 || r == 5)) begin
      i    = $urandom_range(1, pool_count - 1);
      room = int'(pool_start[i]) - int'(pool_end[i-1]) - 1;
    end
    if (room >= 0) begin
      room = room + int'($urandom_range(0, 2)) - 1;
      return (room < 1) ? 1 : (room > POOL_BYTES) ? POOL_BYTES : room;
    end
    if (r == 0) return 0;
    if (r == 1) return POOL_BYTES;
    if (r < 9) return $urandom_range(1, POOL_BYTES);
    return $urandom_range(1, small_max);
  endfunction

  function automatic in_t make_request(phase_e mode);
    in_t req;
    int  r;
    r = $urandom_range(0, 99);
    req.size_bytes    = SIZE_W'($urandom_range(0, POOL_BYTES));
    req.target_offset = OFS_W'($urandom_range(0, POOL_BYTES - 1));
    case (mode)
      PH_FILL:  req.func = (r < 85) ? FUNC_ALLOC : (r < 95) ? FUNC_QUERY : FUNC_RELEASE;
      PH_DRAIN: req.func = (r < 75) ? FUNC_RELEASE : (r < 90) ? FUNC_QUERY : FUNC_ALLOC;
      default:  req.func = (r < 45) ? FUNC_ALLOC : (r < 75) ? FUNC_RELEASE :
                           (r < 97) ? FUNC_QUERY : FUNC_UNUSED;
    endcase
    if (req.func == FUNC_ALLOC) begin
      req.size_bytes = SIZE_W'(pick_size((mode == PH_FILL) ? 16 :
                                         (mode == PH_BIG) ? POOL_BYTES : 64));
    end else if (pool_count != 0 && $urandom_range(0, 4) != 0) begin
      // mostly aim at live blocks, sometimes one byte off
      req.target_offset = pool_start[$urandom_range(0, pool_count - 1)];
      if ($urandom_range(0, 5) == 0)
        req.target_offset = req.target_offset + OFS_W'($urandom_range(0, 2)) - OFS_W'(1);
    end
    return req;
  endfunction

  // one input beat: optional idle, then hold start until the block takes it
  task automatic drive_request(in_t req, int idle, bit typed, out_t lit);
    out_t res;
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = apply_request(req);
    exp_ring[exp_wr % EXP_DEPTH] = typed ? lit : res;
    exp_wr++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_wr == exp_rd) begin
        flag_mismatch("result beat with nothing pending", int'(out_item.status), -1);
      end else begin
        want = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_item.status !== want.status)
          flag_mismatch("status", int'(out_item.status), int'(want.status));
        if (out_item.granted_offset !== want.granted_offset)
          flag_mismatch("granted_offset", int'(out_item.granted_offset),
                        int'(want.granted_offset));
        if (out_item.is_present !== want.is_present)
          flag_mismatch("is_present", int'(out_item.is_present), int'(want.is_present));
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    step_t  plan [24];
    phase_e mode;
    bit     no_idle;
    int     p;
    int     n;
    clk        = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    pool_count = '0;
    err_count  = 0;
    plan = '{
      row(FUNC_QUERY,      0,    0, 1, ST_OK,        0, 0),
      row(FUNC_RELEASE,    0,    0, 1, ST_NOT_FOUND, 0, 0),
      row(FUNC_ALLOC,      0,    0, 1, ST_ZERO,      0, 0),
      row(FUNC_ALLOC,   4096,    0, 1, ST_NO_SPACE,  0, 0),
      row(FUNC_ALLOC,   4095, 4095, 1, ST_OK,        0, 0),
      row(FUNC_QUERY,   4096,    0, 1, ST_OK,        0, 1),
      row(FUNC_QUERY,      0, 4095, 1, ST_OK,        0, 0),
      row(FUNC_ALLOC,      1,    0, 1, ST_NO_SPACE,  0, 0),
      row(FUNC_UNUSED,  4096, 4095, 1, ST_OK,        0, 0),
      row(FUNC_RELEASE,    0,    0, 1, ST_OK,        0, 0),
      row(FUNC_ALLOC,      4,    0, 0, ST_OK,        0, 0),
      row(FUNC_ALLOC,      4,    0, 0, ST_OK,        0, 0),
      row(FUNC_ALLOC,      4,    0, 0, ST_OK,        0, 0),
      row(FUNC_RELEASE,    0,    4, 0, ST_OK,        0, 0),
      row(FUNC_ALLOC,      8,    0, 0, ST_OK,        0, 0),
      row(FUNC_ALLOC,      3,    0, 0, ST_OK,        0, 0),
      row(FUNC_RELEASE,    0,    0, 0, ST_OK,        0, 0),
      row(FUNC_ALLOC,      1,    0, 0, ST_OK,        0, 0),
      row(FUNC_QUERY,      0,    7, 0, ST_OK,        0, 0),
      row(FUNC_RELEASE,    0,   12, 0, ST_OK,        0, 0),
      row(FUNC_ALLOC,   4084,    0, 1, ST_NO_SPACE,  0, 0),
      row(FUNC_ALLOC,   4083,    0, 0, ST_OK,        0, 0),
      row(FUNC_RELEASE,    0, 4095, 1, ST_NOT_FOUND, 0, 0),
      row(FUNC_ALLOC,      1,    0, 1, ST_NO_SPACE,  0, 0)
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      drive_request(plan[i].req, $urandom_range(0, 14), plan[i].typed, plan[i].want);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      mode    = phase_e'(p % 4);
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        drive_request(make_request(mode), no_idle ? 0 : $urandom_range(0, 14), 1'b0, '0);
      if ($urandom_range(0, 2) == 0) wait_idle();
    end

    start <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* first_fit_byte_pool_allocator.f */
rtl/ffbpa_pkg.sv
rtl/ffbpa_datapath.sv
rtl/ffbpa_ctrl.sv
rtl/first_fit_byte_pool_allocator.sv
bench/tb_first_fit_byte_pool_allocator.sv
